FILE: rtl/core/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Used by the store, the sequencer, the top level and the port checker.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int PRI_W     = 8;
	localparam int VAL_W     = 32;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_LIST   = 2'd3;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [PRI_W-1:0] pri;
		logic [VAL_W-1:0] val;
	} spq_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_REM_RD,
		S_REM_WAIT,
		S_LIST_RD,
		S_LIST_WAIT,
		S_EMIT
	} spq_state_t;

endpackage

FILE: rtl/core/spq_store.sv
// Entry store of the priority queue: one write port, one read port with
// registered read data. Depends on spq_pkg for the entry type.
`timescale 1ns / 1ps

module spq_store import spq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  spq_entry_t    wr_entry,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output spq_entry_t    rd_entry
);

	spq_entry_t mem_q [DEPTH];
	spq_entry_t rd_entry_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry_q <= mem_q[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;

endmodule

FILE: rtl/core/spq_ctrl.sv
// Sequencer of the priority queue: request decode, the single priority
// compare, ring addressing of the store and the result register.
// Depends on spq_pkg; drives spq_store.
`timescale 1ns / 1ps

module spq_ctrl import spq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              req_type,
	input  logic [PRI_W-1:0]        in_priority,
	input  logic signed [VAL_W-1:0] in_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic [PRI_W-1:0]        out_priority,
	output logic signed [VAL_W-1:0] out_value,
	output logic                    last,
	output logic                    wr_en,
	output logic [AW-1:0]           wr_addr,
	output spq_entry_t              wr_entry,
	output logic                    rd_en,
	output logic [AW-1:0]           rd_addr,
	input  spq_entry_t              rd_entry
);

	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
	localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] HEAD_TOP = AW'(DEPTH - 1);

	spq_state_t state_q, state_d;

	logic [PRI_W-1:0] pri_q, pri_d;
	logic [VAL_W-1:0] val_q, val_d;
	logic [CW-1:0]    k_q, k_d;
	logic [CW-1:0]    count_q, count_d;
	logic [AW-1:0]    head_q, head_d;

	logic [1:0]       res_status_q, res_status_d;
	logic [PRI_W-1:0] res_pri_q, res_pri_d;
	logic [VAL_W-1:0] res_val_q, res_val_d;
	logic             res_last_q, res_last_d;

	logic             out_valid_q, out_valid_d;
	logic [1:0]       out_status_q, out_status_d;
	logic [PRI_W-1:0] out_pri_q, out_pri_d;
	logic [VAL_W-1:0] out_val_q, out_val_d;
	logic             out_last_q, out_last_d;

	logic [AW-1:0] lk_cur, lk_prev;
	logic [AW:0]   sum_cur, sum_prev;
	logic [AW-1:0] phys_cur, phys_prev;
	logic          pri_ge;
	logic          out_free;

	// logical slot to ring position: one add and one compare-subtract
	assign lk_cur   = k_q[AW-1:0];
	assign lk_prev  = lk_cur - AW'(1);
	assign sum_cur  = {1'b0, head_q} + {1'b0, lk_cur};
	assign sum_prev = {1'b0, head_q} + {1'b0, lk_prev};
	assign phys_cur  = (sum_cur >= DEPTH_W) ? AW'(sum_cur - DEPTH_W) : sum_cur[AW-1:0];
	assign phys_prev = (sum_prev >= DEPTH_W) ? AW'(sum_prev - DEPTH_W) : sum_prev[AW-1:0];

	// the single compare unit
	assign pri_ge   = (rd_entry.pri >= pri_q);
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			head_q      <= head_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pri_q        <= pri_d;
		val_q        <= val_d;
		k_q          <= k_d;
		res_status_q <= res_status_d;
		res_pri_q    <= res_pri_d;
		res_val_q    <= res_val_d;
		res_last_q   <= res_last_d;
		out_status_q <= out_status_d;
		out_pri_q    <= out_pri_d;
		out_val_q    <= out_val_d;
		out_last_q   <= out_last_d;
	end

	always_comb begin
		state_d      = state_q;
		pri_d        = pri_q;
		val_d        = val_q;
		k_d          = k_q;
		count_d      = count_q;
		head_d       = head_q;
		res_status_d = res_status_q;
		res_pri_d    = res_pri_q;
		res_val_d    = res_val_q;
		res_last_d   = res_last_q;
		out_valid_d  = out_valid_q;
		out_status_d = out_status_q;
		out_pri_d    = out_pri_q;
		out_val_d    = out_val_q;
		out_last_d   = out_last_q;
		wr_en        = 1'b0;
		wr_addr      = phys_cur;
		wr_entry     = '{pri: pri_q, val: val_q};
		rd_en        = 1'b0;
		rd_addr      = phys_cur;

		// drop the result once the receiver takes it
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					pri_d        = in_priority;
					val_d        = $unsigned(in_value);
					res_status_d = STAT_OK;
					res_pri_d    = '0;
					res_val_d    = '0;
					res_last_d   = 1'b1;
					k_d          = '0;
					case (req_type)
						REQ_INSERT: begin
							if (count_q == DEPTH_C) begin
								res_status_d = STAT_FULL;
								state_d      = S_EMIT;
							end else begin
								k_d     = count_q;
								state_d = S_INS_RD;
							end
						end
						REQ_REMOVE: begin
							if (count_q == '0) begin
								res_status_d = STAT_EMPTY;
								state_d      = S_EMIT;
							end else begin
								state_d = S_REM_RD;
							end
						end
						REQ_CLEAR: begin
							res_status_d = (count_q == '0) ? STAT_EMPTY : STAT_OK;
							count_d      = '0;
							state_d      = S_EMIT;
						end
						REQ_LIST: begin
							if (count_q == '0) begin
								res_status_d = STAT_EMPTY;
								state_d      = S_EMIT;
							end else begin
								state_d = S_LIST_RD;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			// walk from the tail toward the head, moving lower entries up
			S_INS_RD: begin
				if (k_q == '0) begin
					wr_en   = 1'b1;
					count_d = count_q + CW'(1);
					state_d = S_EMIT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = phys_prev;
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				wr_en = 1'b1;
				if (pri_ge) begin
					count_d = count_q + CW'(1);
					state_d = S_EMIT;
				end else begin
					wr_entry = rd_entry;
					k_d      = k_q - CW'(1);
					state_d  = S_INS_RD;
				end
			end
			S_REM_RD: begin
				rd_en   = 1'b1;
				rd_addr = head_q;
				state_d = S_REM_WAIT;
			end
			S_REM_WAIT: begin
				res_pri_d = rd_entry.pri;
				res_val_d = rd_entry.val;
				head_d    = (head_q == HEAD_TOP) ? '0 : head_q + AW'(1);
				count_d   = count_q - CW'(1);
				state_d   = S_EMIT;
			end
			S_LIST_RD: begin
				rd_en   = 1'b1;
				state_d = S_LIST_WAIT;
			end
			S_LIST_WAIT: begin
				res_status_d = STAT_OK;
				res_pri_d    = rd_entry.pri;
				res_val_d    = rd_entry.val;
				res_last_d   = ((k_q + CW'(1)) == count_q);
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				// hold until the output register is free
				if (out_free) begin
					out_valid_d  = 1'b1;
					out_status_d = res_status_q;
					out_pri_d    = res_pri_q;
					out_val_d    = res_val_q;
					out_last_d   = res_last_q;
					if (res_last_q) begin
						state_d = S_IDLE;
					end else begin
						k_d     = k_q + CW'(1);
						state_d = S_LIST_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign out_priority = out_pri_q;
	assign out_value    = $signed(out_val_q);
	assign last         = out_last_q;

endmodule

FILE: rtl/core/sorted_priority_queue_unit.sv
// Sorted priority queue: up to DEPTH (priority, value) entries kept in
// descending priority, equal priorities in arrival order.
//
// Input channel (in_valid / in_stall): one transaction is one request,
// req_type 0 insert, 1 remove head, 2 clear, 3 list. in_stall is high from
// the cycle after a transaction until its last result has been loaded into
// the output register.
// Output channel (out_valid / out_stall): one result per transaction,
// except list, which gives one result per entry head first; last marks the
// final result of a request. A result waits in the output register while
// out_stall is high; the next request is taken meanwhile.
// Requests run one store access at a time through the single store port and
// the single priority compare: insert reads and compares the entries it
// passes on the way from the tail, remove reads the head, and list reads
// one entry at a time from the head; out_stall can hold any of them.
// Reset empties the queue at once; store contents are not cleared.
// Depends on spq_pkg, spq_store and spq_ctrl.
`timescale 1ns / 1ps

module sorted_priority_queue_unit import spq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              req_type,
	input  logic [PRI_W-1:0]        in_priority,
	input  logic signed [VAL_W-1:0] in_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic [PRI_W-1:0]        out_priority,
	output logic signed [VAL_W-1:0] out_value,
	output logic                    last
);

	localparam int AW = $clog2(DEPTH);

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	spq_entry_t    wr_entry;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	spq_entry_t    rd_entry;

	spq_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.in_priority (in_priority),
		.in_value    (in_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_priority(out_priority),
		.out_value   (out_value),
		.last        (last),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_entry    (wr_entry),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_entry    (rd_entry)
	);

	spq_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_entry(wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_entry(rd_entry)
	);

endmodule

FILE: rtl/core/spq_checker.sv
// Port checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg for the status codes.
`timescale 1ns / 1ps

module spq_checker import spq_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [1:0]       status,
	input logic [PRI_W-1:0] out_priority,
	input logic [VAL_W-1:0] out_value,
	input logic             last
);

	// a waiting result is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// one request at a time: no transaction in the cycle after one
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one in progress");

	// error results carry no entry and end the request
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> last && out_priority == '0 && out_value == '0)
		else $error("error result with entry data or without last");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STAT_OK || status == STAT_EMPTY || status == STAT_FULL)
		else $error("undefined status code");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.out_priority(out_priority),
	.out_value   (out_value),
	.last        (last)
);

FILE: tb/queue_tracker_pkg.sv
// Scoreboard for the sorted priority queue testbench: a shadow copy of the
// ordered store plus the list of results still owed by the block.
// Depends on spq_pkg for widths, request codes and status codes.
`timescale 1ns / 1ps

package queue_tracker_pkg;
	import spq_pkg::*;

	typedef struct packed {
		logic [1:0]       status;
		logic [PRI_W-1:0] pri;
		logic [VAL_W-1:0] val;
		logic             last;
	} queue_result_t;

	class queue_tracker;
		logic [PRI_W-1:0] slot_pri [DEPTH_DEF];
		logic [VAL_W-1:0] slot_val [DEPTH_DEF];
		int unsigned      fill;
		queue_result_t    pending_results [$];
		int unsigned      mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function void owe(logic [1:0] st, logic [PRI_W-1:0] pri, logic [VAL_W-1:0] val,
				logic lst);
			queue_result_t r;
			r.status = st;
			r.pri = pri;
			r.val = val;
			r.last = lst;
			pending_results.push_back(r);
		endfunction

		// Apply one accepted request to the shadow store and queue its results.
		function void take_request(logic [1:0] req, logic [PRI_W-1:0] pri,
				logic [VAL_W-1:0] val);
			int unsigned pos;
			case (req)
				REQ_INSERT: begin
					if (fill >= DEPTH_DEF) begin
						owe(STAT_FULL, '0, '0, 1'b1);
					end else begin
						pos = 0;
						// equal priorities keep arrival order: skip past them
						while (pos < fill && slot_pri[pos] >= pri)
							pos++;
						for (int unsigned i = fill; i > pos; i--) begin
							slot_pri[i] = slot_pri[i - 1];
							slot_val[i] = slot_val[i - 1];
						end
						slot_pri[pos] = pri;
						slot_val[pos] = val;
						fill++;
						owe(STAT_OK, '0, '0, 1'b1);
					end
				end
				REQ_REMOVE: begin
					if (fill == 0) begin
						owe(STAT_EMPTY, '0, '0, 1'b1);
					end else begin
						owe(STAT_OK, slot_pri[0], slot_val[0], 1'b1);
						for (int unsigned i = 1; i < fill; i++) begin
							slot_pri[i - 1] = slot_pri[i];
							slot_val[i - 1] = slot_val[i];
						end
						fill--;
					end
				end
				REQ_CLEAR: begin
					owe((fill == 0) ? STAT_EMPTY : STAT_OK, '0, '0, 1'b1);
					fill = 0;
				end
				default: begin
					if (fill == 0) begin
						owe(STAT_EMPTY, '0, '0, 1'b1);
					end else begin
						for (int unsigned i = 0; i < fill; i++)
							owe(STAT_OK, slot_pri[i], slot_val[i], (i + 1 == fill));
					end
				end
			endcase
		endfunction

		// Compare one accepted result against the oldest owed result.
		function void match_result(logic [1:0] st, logic [PRI_W-1:0] pri,
				logic [VAL_W-1:0] val, logic lst);
			queue_result_t want;
			bit bad;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result status=%0d pri=%0d val=%h last=%0d",
					$time, st, pri, val, lst);
				return;
			end
			want = pending_results.pop_front();
			bad = (st !== want.status) || (pri !== want.pri) || (val !== want.val)
				|| (lst !== want.last);
			if (bad) begin
				mismatches++;
				$display("%0t: expected status=%0d pri=%0d val=%h last=%0d,%s",
					$time, want.status, want.pri, want.val, want.last,
					$sformatf(" got status=%0d pri=%0d val=%h last=%0d",
						st, pri, val, lst));
			end
		endfunction
	endclass

endpackage

FILE: tb/tb_top.sv
// Top of the sorted priority queue testbench: clock, reset, request driver
// and result monitor around sorted_priority_queue_unit.
// Depends on spq_pkg and queue_tracker_pkg.
`timescale 1ns / 1ps

module tb_top;
	import spq_pkg::*;
	import queue_tracker_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_ITEMS = 320;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [1:0]              req_type = REQ_INSERT;
	logic [PRI_W-1:0]        in_priority = '0;
	logic signed [VAL_W-1:0] in_value = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [1:0]              status;
	logic [PRI_W-1:0]        out_priority;
	logic signed [VAL_W-1:0] out_value;
	logic                    last;

	queue_tracker tracker;
	bit           calm_window = 1'b0;
	int unsigned  cycles = 0;

	sorted_priority_queue_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.in_priority (in_priority),
		.in_value    (in_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_priority(out_priority),
		.out_value   (out_value),
		.last        (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic bit idle_roll();
		return !calm_window && ($urandom_range(99) < 21);
	endfunction

	// Check the result first, then pick the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.match_result(status, out_priority, out_value, last);
		out_stall <= idle_roll();
	end

	task automatic issue(input logic [1:0] req, input logic [PRI_W-1:0] pri,
			input logic [VAL_W-1:0] val);
		int gap;
		gap = idle_roll() ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		in_priority <= pri;
		in_value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_request(req, pri, val);
	endtask

	// Alternate fill-leaning and drain-leaning stretches so full and empty
	// are both reached; narrow priorities half the time to force ties.
	task automatic random_traffic(input int count);
		int roll;
		logic [1:0] req;
		logic [PRI_W-1:0] pri;
		for (int n = 0; n < count; n++) begin
			calm_window = (n >= 120 && n < 180);
			roll = $urandom_range(99);
			if ((n / 40) % 2 == 0)
				req = (roll < 68) ? REQ_INSERT : (roll < 84) ? REQ_REMOVE :
					(roll < 96) ? REQ_LIST : REQ_CLEAR;
			else
				req = (roll < 22) ? REQ_INSERT : (roll < 84) ? REQ_REMOVE :
					(roll < 97) ? REQ_LIST : REQ_CLEAR;
			pri = $urandom_range(1) ? PRI_W'($urandom_range(3)) :
				PRI_W'($urandom_range(255));
			issue(req, pri, $urandom);
		end
		calm_window = 1'b0;
	endtask

	initial begin
		tracker = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store: remove, clear and list all report empty
		issue(REQ_REMOVE, 8'hFF, 32'hFFFF_FFFF);
		issue(REQ_CLEAR, 8'h00, 32'h0000_0000);
		issue(REQ_LIST, 8'hAA, 32'h5555_5555);
		// extremes, and a tie that must land behind the earlier entry
		issue(REQ_INSERT, 8'd0, 32'h8000_0000);
		issue(REQ_INSERT, 8'd255, 32'h7FFF_FFFF);
		issue(REQ_INSERT, 8'd255, 32'hFFFF_FFFF);
		issue(REQ_INSERT, 8'd128, 32'h0000_0000);
		issue(REQ_LIST, 8'h00, 32'h0000_0000);
		issue(REQ_REMOVE, 8'h00, 32'h0000_0000);
		// fill to capacity, then overflow, list a full store and clear it
		for (int i = 0; i < 13; i++)
			issue(REQ_INSERT, (i % 4 == 0) ? 8'd0 : 8'(i * 19), $urandom);
		issue(REQ_INSERT, 8'd200, 32'h1234_5678);
		issue(REQ_LIST, 8'hFF, 32'hFFFF_FFFF);
		issue(REQ_CLEAR, 8'hFF, 32'hFFFF_FFFF);

		random_traffic(RANDOM_ITEMS);
		in_valid <= 1'b0;

		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.pending_results.size() != 0)
			tracker.mismatches++;
		if (tracker.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
